### hw/rtl/asrd_pkg.sv
// Shared types and constants for the analog stick radial dead zone.
// Holds the sample, result and sideband item structs; no dependencies.
package asrd_pkg;

    localparam int SAMPLE_BITS   = 12;
    localparam int OUT_BITS      = 16;
    localparam int CFG_DATA_BITS = 16;
    localparam int CFG_IDX_BITS  = 3;
    localparam int FRAC_BITS     = 16;
    localparam int AXIS_BITS     = FRAC_BITS + 1;
    localparam int DEF_OUT_FRAC  = 14;

    localparam logic [CFG_IDX_BITS-1:0] REG_X_LOW      = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_X_CENTER   = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_X_HIGH     = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_Y_LOW      = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_Y_CENTER   = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_Y_HIGH     = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] REG_DEAD_INNER = 3'd6;
    localparam logic [CFG_IDX_BITS-1:0] REG_DEAD_OUTER = 3'd7;

    localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = {SAMPLE_BITS{1'b1}};
    localparam logic [SAMPLE_BITS-1:0] SAMPLE_MID = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic [15:0] DEAD_INNER_RST = 16'd9830;
    localparam logic [15:0] DEAD_OUTER_RST = 16'd6554;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] x_raw;
        logic [SAMPLE_BITS-1:0] y_raw;
    } sample_t;

    typedef struct packed {
        logic signed [OUT_BITS-1:0] x_out;
        logic signed [OUT_BITS-1:0] y_out;
    } result_t;

    typedef struct packed {
        logic [AXIS_BITS-1:0] ax;
        logic [AXIS_BITS-1:0] ay;
        logic                 nx;
        logic                 ny;
    } vec_side_t;

    typedef struct packed {
        vec_side_t            vec;
        logic [AXIS_BITS-1:0] m;
    } mag_side_t;

endpackage

### hw/rtl/asrd_fdiv.sv
// Pipelined restoring fraction divider, one quotient bit per stage.
// Requires num <= den and den != 0; uses no package.
module asrd_fdiv #(
    parameter int W      = 17,
    parameter int STEPS  = 16,
    parameter int SIDE_W = 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              adv,
    input  logic              in_valid,
    input  logic [W-1:0]      num,
    input  logic [W-1:0]      den,
    input  logic [SIDE_W-1:0] side_in,
    output logic              out_valid,
    output logic [STEPS:0]    quo,
    output logic [SIDE_W-1:0] side_out
);

    logic              valid_reg [0:STEPS];
    logic [W-1:0]      rem_reg   [0:STEPS];
    logic [W-1:0]      den_reg   [0:STEPS];
    logic [STEPS:0]    q_reg     [0:STEPS];
    logic [SIDE_W-1:0] side_reg  [0:STEPS];

    logic ge0;
    assign ge0 = (num >= den);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg[0] <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rem_reg[0]  <= ge0 ? (num - den) : num;
            den_reg[0]  <= den;
            q_reg[0]    <= {{STEPS{1'b0}}, ge0};
            side_reg[0] <= side_in;
        end
    end

    for (genvar i = 1; i <= STEPS; i++)
    begin : g_step
        logic [W:0]   rem2;
        logic [W:0]   diff;
        logic         ge;
        logic [W-1:0] rem_next;

        always_comb
        begin
            rem2     = {rem_reg[i-1], 1'b0};
            diff     = rem2 - {1'b0, den_reg[i-1]};
            ge       = (rem2 >= {1'b0, den_reg[i-1]});
            rem_next = ge ? diff[W-1:0] : rem2[W-1:0];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[i] <= 1'b0;
            end
            else if (adv)
            begin
                valid_reg[i] <= valid_reg[i-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rem_reg[i]  <= rem_next;
                den_reg[i]  <= den_reg[i-1];
                q_reg[i]    <= {q_reg[i-1][STEPS-1:0], ge};
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    assign out_valid = valid_reg[STEPS];
    assign quo       = q_reg[STEPS];
    assign side_out  = side_reg[STEPS];

endmodule

### hw/rtl/asrd_sqrt.sv
// Pipelined restoring integer square root, one root bit per stage.
// Floor root of a 2*ROOT_W bit radicand; uses no package.
module asrd_sqrt #(
    parameter int ROOT_W = 17,
    parameter int SIDE_W = 1
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                adv,
    input  logic                in_valid,
    input  logic [2*ROOT_W-1:0] rad,
    input  logic [SIDE_W-1:0]   side_in,
    output logic                out_valid,
    output logic [ROOT_W-1:0]   root,
    output logic [SIDE_W-1:0]   side_out
);

    localparam int REM_W = ROOT_W + 4;

    logic                valid_reg [0:ROOT_W-1];
    logic [REM_W-1:0]    rem_reg   [0:ROOT_W-1];
    logic [ROOT_W-1:0]   root_reg  [0:ROOT_W-1];
    logic [2*ROOT_W-1:0] rad_reg   [0:ROOT_W-1];
    logic [SIDE_W-1:0]   side_reg  [0:ROOT_W-1];

    for (genvar i = 0; i < ROOT_W; i++)
    begin : g_step
        logic                src_valid;
        logic [REM_W-1:0]    src_rem;
        logic [ROOT_W-1:0]   src_root;
        logic [2*ROOT_W-1:0] src_rad;
        logic [SIDE_W-1:0]   src_side;
        logic [REM_W-1:0]    rem4;
        logic [REM_W-1:0]    trial;
        logic                ge;

        if (i == 0)
        begin : g_first
            assign src_valid = in_valid;
            assign src_rem   = '0;
            assign src_root  = '0;
            assign src_rad   = rad;
            assign src_side  = side_in;
        end
        else
        begin : g_next
            assign src_valid = valid_reg[i-1];
            assign src_rem   = rem_reg[i-1];
            assign src_root  = root_reg[i-1];
            assign src_rad   = rad_reg[i-1];
            assign src_side  = side_reg[i-1];
        end

        always_comb
        begin
            rem4  = {src_rem[REM_W-3:0], src_rad[2*ROOT_W-1 -: 2]};
            trial = {{(REM_W-ROOT_W-2){1'b0}}, src_root, 2'b01};
            ge    = (rem4 >= trial);
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[i] <= 1'b0;
            end
            else if (adv)
            begin
                valid_reg[i] <= src_valid;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rem_reg[i]  <= ge ? (rem4 - trial) : rem4;
                root_reg[i] <= {src_root[ROOT_W-2:0], ge};
                rad_reg[i]  <= {src_rad[2*ROOT_W-3:0], 2'b00};
                side_reg[i] <= src_side;
            end
        end
    end

    assign out_valid = valid_reg[ROOT_W-1];
    assign root      = root_reg[ROOT_W-1];
    assign side_out  = side_reg[ROOT_W-1];

endmodule

### hw/rtl/analog_stick_radial_deadzone.sv
// Top level of the analog stick radial dead zone pipeline.
// Depends on asrd_pkg, asrd_fdiv and asrd_sqrt.
//
// Usage:
//   sample channel (sample_valid/sample_ready, sample) takes one raw
//   (x_raw, y_raw) pair; result channel (result_valid/result_ready, result)
//   gives the matching signed Q1.14 (x_out, y_out) pair, one per sample,
//   in order.
//   Calibration and dead zones are written through cfg_we/cfg_index/cfg_data;
//   the user must write them only while the pipeline is empty; the block has no check for this.
//   Throughput: one item per cycle while no result is stalled. Items pass the
//   input register, bit-per-stage axis dividers, squares register, square root,
//   rescale divider, products register, output dividers and output register.
//   The whole pipeline advances together; when the receiver holds
//   result_ready low with a result waiting, every stage holds and
//   sample_ready drops, so nothing is lost or repeated.
//   Reset clears all stage valid bits and loads the default calibration.
module analog_stick_radial_deadzone
    import asrd_pkg::*;
#(
    parameter int OUT_FRAC_BITS = DEF_OUT_FRAC
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     sample_valid,
    output logic                     sample_ready,
    input  sample_t                  sample,
    output logic                     result_valid,
    input  logic                     result_ready,
    output result_t                  result,
    input  logic                     cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data
);

    localparam int SB    = SAMPLE_BITS;
    localparam int AW    = AXIS_BITS;
    localparam int PW    = 2 * AW;
    localparam int MAG_W = OUT_FRAC_BITS + 1;

    logic [SB-1:0] x_low_reg, x_center_reg, x_high_reg;
    logic [SB-1:0] y_low_reg, y_center_reg, y_high_reg;
    logic [15:0]   dead_inner_reg, dead_outer_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_low_reg      <= '0;
            x_center_reg   <= SAMPLE_MID;
            x_high_reg     <= SAMPLE_MAX;
            y_low_reg      <= '0;
            y_center_reg   <= SAMPLE_MID;
            y_high_reg     <= SAMPLE_MAX;
            dead_inner_reg <= DEAD_INNER_RST;
            dead_outer_reg <= DEAD_OUTER_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_X_LOW:      x_low_reg      <= cfg_data[SB-1:0];
                REG_X_CENTER:   x_center_reg   <= cfg_data[SB-1:0];
                REG_X_HIGH:     x_high_reg     <= cfg_data[SB-1:0];
                REG_Y_LOW:      y_low_reg      <= cfg_data[SB-1:0];
                REG_Y_CENTER:   y_center_reg   <= cfg_data[SB-1:0];
                REG_Y_HIGH:     y_high_reg     <= cfg_data[SB-1:0];
                REG_DEAD_INNER: dead_inner_reg <= cfg_data[15:0];
                REG_DEAD_OUTER: dead_outer_reg <= cfg_data[15:0];
                default:        ;
            endcase
        end
    end

    logic adv;
    logic out_valid_reg;
    assign adv          = !out_valid_reg || result_ready;
    assign sample_ready = adv;

    // input stage
    logic    a_valid_reg;
    sample_t a_item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_valid_reg <= sample_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_item_reg <= sample;
        end
    end

    function automatic logic [2*SB:0] axis_prep(input logic [SB-1:0] raw,
                                                 input logic [SB-1:0] lo,
                                                 input logic [SB-1:0] c,
                                                 input logic [SB-1:0] hi);
        logic [SB-1:0] v;
        logic [SB-1:0] num;
        logic [SB-1:0] den;
        logic          neg;
        logic          zero;
        begin
            v    = raw;
            neg  = 1'b0;
            zero = 1'b0;
            num  = '0;
            den  = '0;
            if (v < lo)
                v = lo;
            else if (v > hi)
                v = hi;
            if (v >= c)
            begin
                zero = (hi <= c);
                num  = v - c;
                den  = hi - c;
            end
            else
            begin
                zero = (c <= lo);
                num  = c - v;
                den  = c - lo;
                neg  = 1'b1;
            end
            if (num > den)
                num = den;
            if (zero)
            begin
                num = '0;
                den = {{(SB-1){1'b0}}, 1'b1};
            end
            axis_prep = {neg, num, den};
        end
    endfunction

    logic [2*SB:0] prep_x, prep_y;
    assign prep_x = axis_prep(a_item_reg.x_raw, x_low_reg, x_center_reg, x_high_reg);
    assign prep_y = axis_prep(a_item_reg.y_raw, y_low_reg, y_center_reg, y_high_reg);

    logic          fx_valid, fy_valid;
    logic [AW-1:0] fx_quo, fy_quo;
    logic          fx_neg, fy_neg;

    asrd_fdiv #(.W(SB), .STEPS(FRAC_BITS), .SIDE_W(1)) u_div_x (
        .clk(clk), .rst_n(rst_n), .adv(adv),
        .in_valid(a_valid_reg),
        .num(prep_x[2*SB-1:SB]), .den(prep_x[SB-1:0]), .side_in(prep_x[2*SB]),
        .out_valid(fx_valid), .quo(fx_quo), .side_out(fx_neg)
    );

    asrd_fdiv #(.W(SB), .STEPS(FRAC_BITS), .SIDE_W(1)) u_div_y (
        .clk(clk), .rst_n(rst_n), .adv(adv),
        .in_valid(a_valid_reg),
        .num(prep_y[2*SB-1:SB]), .den(prep_y[SB-1:0]), .side_in(prep_y[2*SB]),
        .out_valid(fy_valid), .quo(fy_quo), .side_out(fy_neg)
    );

    // squares
    logic          b_valid_reg;
    logic [PW-1:0] b_sqx_reg, b_sqy_reg;
    vec_side_t     b_vec_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            b_valid_reg <= fx_valid && fy_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            b_sqx_reg    <= fx_quo * fx_quo;
            b_sqy_reg    <= fy_quo * fy_quo;
            b_vec_reg.ax <= fx_quo;
            b_vec_reg.ay <= fy_quo;
            b_vec_reg.nx <= fx_neg;
            b_vec_reg.ny <= fy_neg;
        end
    end

    logic [PW-1:0] sq_sum;
    assign sq_sum = b_sqx_reg + b_sqy_reg;

    logic          sq_valid;
    logic [AW-1:0] sq_root;
    vec_side_t     sq_vec;

    asrd_sqrt #(.ROOT_W(AW), .SIDE_W($bits(vec_side_t))) u_sqrt (
        .clk(clk), .rst_n(rst_n), .adv(adv),
        .in_valid(b_valid_reg), .rad(sq_sum), .side_in(b_vec_reg),
        .out_valid(sq_valid), .root(sq_root), .side_out(sq_vec)
    );

    // rescale between inner and outer dead zones
    logic          dz_zero, dz_sat;
    logic [17:0]   legal;
    logic [AW-1:0] dz_d, dz_num, dz_den;
    mag_side_t     dz_side;

    always_comb
    begin
        legal   = 18'(1 << FRAC_BITS) - {2'b00, dead_outer_reg} - {2'b00, dead_inner_reg};
        dz_zero = (sq_root <= {1'b0, dead_inner_reg});
        dz_d    = sq_root - {1'b0, dead_inner_reg};
        dz_sat  = legal[17] || (legal == '0) || ({1'b0, dz_d} >= legal);
        if (dz_zero)
        begin
            dz_num = '0;
            dz_den = {{(AW-1){1'b0}}, 1'b1};
        end
        else if (dz_sat)
        begin
            dz_num = {{(AW-1){1'b0}}, 1'b1};
            dz_den = {{(AW-1){1'b0}}, 1'b1};
        end
        else
        begin
            dz_num = dz_d;
            dz_den = legal[AW-1:0];
        end
        dz_side.vec = sq_vec;
        dz_side.m   = sq_root;
    end

    logic          nd_valid;
    logic [AW-1:0] nd_quo;
    mag_side_t     nd_side;

    asrd_fdiv #(.W(AW), .STEPS(FRAC_BITS), .SIDE_W($bits(mag_side_t))) u_div_n (
        .clk(clk), .rst_n(rst_n), .adv(adv),
        .in_valid(sq_valid), .num(dz_num), .den(dz_den), .side_in(dz_side),
        .out_valid(nd_valid), .quo(nd_quo), .side_out(nd_side)
    );

    // products for the common scale factor
    logic          c_valid_reg;
    logic [PW-1:0] c_px_reg, c_py_reg, c_den_reg;
    logic          c_nx_reg, c_ny_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            c_valid_reg <= nd_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            c_px_reg  <= nd_side.vec.ax * nd_quo;
            c_py_reg  <= nd_side.vec.ay * nd_quo;
            c_den_reg <= (nd_side.m == '0) ? PW'(1) : {1'b0, nd_side.m, {FRAC_BITS{1'b0}}};
            c_nx_reg  <= nd_side.vec.nx;
            c_ny_reg  <= nd_side.vec.ny;
        end
    end

    logic             ox_valid, oy_valid;
    logic [MAG_W-1:0] ox_mag, oy_mag;
    logic             ox_neg, oy_neg;

    asrd_fdiv #(.W(PW), .STEPS(OUT_FRAC_BITS), .SIDE_W(1)) u_div_ox (
        .clk(clk), .rst_n(rst_n), .adv(adv),
        .in_valid(c_valid_reg), .num(c_px_reg), .den(c_den_reg), .side_in(c_nx_reg),
        .out_valid(ox_valid), .quo(ox_mag), .side_out(ox_neg)
    );

    asrd_fdiv #(.W(PW), .STEPS(OUT_FRAC_BITS), .SIDE_W(1)) u_div_oy (
        .clk(clk), .rst_n(rst_n), .adv(adv),
        .in_valid(c_valid_reg), .num(c_py_reg), .den(c_den_reg), .side_in(c_ny_reg),
        .out_valid(oy_valid), .quo(oy_mag), .side_out(oy_neg)
    );

    function automatic logic [OUT_BITS-1:0] pack_out(input logic [MAG_W-1:0] mag,
                                                      input logic neg);
        logic [31:0]         wide;
        logic [OUT_BITS-1:0] m16;
        begin
            wide = 32'(mag);
            if (wide > 32'd32767)
                m16 = 16'd32767;
            else
                m16 = wide[OUT_BITS-1:0];
            pack_out = neg ? (~m16 + 16'd1) : m16;
        end
    endfunction

    result_t out_item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= ox_valid && oy_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_item_reg.x_out <= pack_out(ox_mag, ox_neg);
            out_item_reg.y_out <= pack_out(oy_mag, oy_neg);
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_item_reg;

endmodule

### hw/rtl/asrd_checker.sv
// Port-level checks for the analog stick radial dead zone.
// Depends on asrd_pkg; bound to analog_stick_radial_deadzone.
module asrd_checker
    import asrd_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    sample_ready,
    input logic    result_valid,
    input logic    result_ready,
    input result_t result
);

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid)
        else $error("result item dropped while stalled");

    a_hold_item: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> $stable(result))
        else $error("result item changed while stalled");

    a_stall_only: assert property (@(posedge clk) disable iff (!rst_n)
        !sample_ready |-> result_valid && !result_ready)
        else $error("sample side held without a stalled result");

    a_empty_after_reset: assert property (@(posedge clk)
        $rose(rst_n) |-> !result_valid)
        else $error("result valid straight after reset");

endmodule

bind analog_stick_radial_deadzone asrd_checker u_asrd_checker (
    .clk(clk),
    .rst_n(rst_n),
    .sample_ready(sample_ready),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result(result)
);

### verif/analog_stick_radial_deadzone_tb.sv
// Testbench for analog_stick_radial_deadzone: drives raw stick samples under
// several calibrations and idling patterns and checks each result against an
// in-bench fixed-point predictor. Depends on asrd_pkg and the block's RTL.
module analog_stick_radial_deadzone_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import asrd_pkg::*;

    localparam int OUT_FRAC   = DEF_OUT_FRAC;
    localparam int LATENCY    = 56 + OUT_FRAC;
    localparam int CYCLE_CAP  = 400000;

    logic                     clk;
    logic                     rst_n;
    logic                     sample_valid;
    logic                     sample_ready;
    sample_t                  sample;
    logic                     result_valid;
    logic                     result_ready;
    result_t                  result;
    logic                     cfg_we;
    logic [CFG_IDX_BITS-1:0]  cfg_index;
    logic [CFG_DATA_BITS-1:0] cfg_data;

    logic [11:0] cal_x_low, cal_x_center, cal_x_high;
    logic [11:0] cal_y_low, cal_y_center, cal_y_high;
    logic [15:0] cal_inner, cal_outer;

    result_t pending_results[$];
    int      send_idle_pct;
    int      recv_stall_pct;
    int      cycle_count;
    bit      failed;

    analog_stick_radial_deadzone i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample       (sample),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic logic [16:0] axis_frac(input logic [11:0] raw, input logic [11:0] lo,
                                              input logic [11:0] c, input logic [11:0] hi,
                                              output bit neg);
        longint v;
        longint num;
        longint den;
        v = raw;
        neg = 1'b0;
        if (v < lo)
            v = lo;
        else if (v > hi)
            v = hi;
        if (v >= c)
        begin
            if (hi <= c)
                return 17'd0;
            num = v - c;
            den = hi - c;
        end
        else
        begin
            if (c <= lo)
                return 17'd0;
            num = c - v;
            den = c - lo;
            neg = 1'b1;
        end
        if (num > den)
            num = den;
        return 17'((num * 65536) / den);
    endfunction

    function automatic longint isqrt(input longint n);
        longint r;
        longint b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n)
            b = b >> 2;
        while (b != 0)
        begin
            if (n >= r + b)
            begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic logic [15:0] pack_axis(input longint mag, input bit neg);
        if (mag > 32767)
            mag = 32767;
        if (neg && mag != 0)
            return 16'(65536 - mag);
        return 16'(mag);
    endfunction

    function automatic result_t deadzone_predict(input sample_t s);
        result_t r;
        bit      nx;
        bit      ny;
        longint  ax;
        longint  ay;
        longint  m;
        longint  n;
        longint  legal;
        ax = axis_frac(s.x_raw, cal_x_low, cal_x_center, cal_x_high, nx);
        ay = axis_frac(s.y_raw, cal_y_low, cal_y_center, cal_y_high, ny);
        m = isqrt(ax * ax + ay * ay);
        r = '0;
        if (m <= cal_inner)
            return r;
        legal = 65536 - longint'(cal_outer) - longint'(cal_inner);
        if (legal <= 0)
            n = 65536;
        else
        begin
            n = ((m - cal_inner) * 65536) / legal;
            if (n > 65536)
                n = 65536;
        end
        r.x_out = pack_axis(((ax * n) << OUT_FRAC) / (m * 65536), nx);
        r.y_out = pack_axis(((ay * n) << OUT_FRAC) / (m * 65536), ny);
        return r;
    endfunction

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [15:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        @(negedge clk);
        case (idx)
            REG_X_LOW:      cal_x_low = val[11:0];
            REG_X_CENTER:   cal_x_center = val[11:0];
            REG_X_HIGH:     cal_x_high = val[11:0];
            REG_Y_LOW:      cal_y_low = val[11:0];
            REG_Y_CENTER:   cal_y_center = val[11:0];
            REG_Y_HIGH:     cal_y_high = val[11:0];
            REG_DEAD_INNER: cal_inner = val;
            REG_DEAD_OUTER: cal_outer = val;
            default: ;
        endcase
    endtask

    task automatic drain_results();
        sample_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (LATENCY + 10) @(negedge clk);
    endtask

    task automatic load_calibration(input logic [11:0] xl, input logic [11:0] xc,
                                    input logic [11:0] xh, input logic [11:0] yl,
                                    input logic [11:0] yc, input logic [11:0] yh,
                                    input logic [15:0] di, input logic [15:0] dout);
        drain_results();
        write_reg(REG_X_LOW, {4'hA, xl});
        write_reg(REG_X_CENTER, {4'h5, xc});
        write_reg(REG_X_HIGH, {4'hF, xh});
        write_reg(REG_Y_LOW, {4'h0, yl});
        write_reg(REG_Y_CENTER, {4'h3, yc});
        write_reg(REG_Y_HIGH, {4'hC, yh});
        write_reg(REG_DEAD_INNER, di);
        write_reg(REG_DEAD_OUTER, dout);
        cfg_we <= 1'b0;
    endtask

    task automatic send_sample(input logic [11:0] xr, input logic [11:0] yr);
        while ($urandom_range(99) < send_idle_pct)
        begin
            sample_valid <= 1'b0;
            @(negedge clk);
        end
        sample_valid <= 1'b1;
        sample.x_raw <= xr;
        sample.y_raw <= yr;
        @(posedge clk);
        while (!sample_ready)
            @(posedge clk);
        pending_results.push_back(deadzone_predict(sample));
        @(negedge clk);
    endtask

    task automatic send_random(input int count);
        int k;
        for (k = 0; k < count; k++)
        begin
            case ($urandom_range(3))
                0: send_sample(12'($urandom), 12'($urandom));
                1: send_sample(12'(cal_x_center + $urandom_range(80) - 40),
                               12'(cal_y_center + $urandom_range(80) - 40));
                2: send_sample($urandom_range(1) ? 12'hFFF : 12'h000, 12'($urandom));
                default: send_sample(12'($urandom), $urandom_range(1) ? 12'hFFF : 12'h000);
            endcase
        end
    endtask

    task automatic test_directed_defaults();
        send_sample(12'd2047, 12'd2047);
        send_sample(12'd0, 12'd2047);
        send_sample(12'd4095, 12'd2047);
        send_sample(12'd2047, 12'd0);
        send_sample(12'd2047, 12'd4095);
        send_sample(12'd0, 12'd0);
        send_sample(12'd4095, 12'd4095);
        send_sample(12'd2400, 12'd2047);
        send_sample(12'd2047, 12'd1740);
        send_sample(12'd2350, 12'd2350);
        send_sample(12'hAAA, 12'h555);
        send_sample(12'h555, 12'hAAA);
    endtask

    task automatic test_special_calibrations();
        load_calibration(12'd3000, 12'd2000, 12'd1000, 12'd100, 12'd100, 12'd4000,
                         16'd0, 16'd0);
        send_sample(12'd0, 12'd0);
        send_sample(12'd4095, 12'd4095);
        send_sample(12'd2500, 12'd50);
        send_sample(12'd1500, 12'd3000);
        load_calibration(12'd500, 12'd4000, 12'd4000, 12'd0, 12'd0, 12'd0,
                         16'hFFFF, 16'hFFFF);
        send_sample(12'd0, 12'd4095);
        send_sample(12'd4095, 12'd0);
        load_calibration(12'd200, 12'd2100, 12'd3900, 12'd300, 12'd1900, 12'd3800,
                         16'd40000, 16'd30000);
        send_sample(12'd3900, 12'd3800);
        send_sample(12'd200, 12'd300);
        send_sample(12'd4095, 12'd0);
    endtask

    task automatic test_idle_phases();
        load_calibration(12'd0, 12'd2047, 12'd4095, 12'd0, 12'd2047, 12'd4095,
                         16'd9830, 16'd6554);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        send_random(100);
        send_idle_pct = 72;
        send_random(70);
        drain_results();
        send_idle_pct = 0;
        recv_stall_pct = 72;
        send_random(70);
        send_idle_pct = 22;
        recv_stall_pct = 22;
        send_random(60);
    endtask

    task automatic test_random_calibrations();
        int p;
        logic [11:0] xc;
        logic [11:0] yc;
        for (p = 0; p < 4; p++)
        begin
            xc = 12'($urandom_range(500, 3500));
            yc = 12'($urandom_range(500, 3500));
            load_calibration(12'($urandom_range(xc)), xc, 12'($urandom_range(4095, xc)),
                             12'($urandom_range(yc)), yc, 12'($urandom_range(4095, yc)),
                             16'($urandom_range(30000)), 16'($urandom_range(30000)));
            send_idle_pct = p * 20;
            recv_stall_pct = 60 - p * 20;
            send_random(25);
        end
    endtask

    always @(negedge clk)
        result_ready <= !rst_n ? 1'b0 : ($urandom_range(99) >= recv_stall_pct);

    always @(posedge clk)
    begin
        result_t want;
        cycle_count <= cycle_count + 1;
        if (rst_n && result_valid && result_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected item x=%0d y=%0d", $time, result.x_out, result.y_out);
                failed = 1'b1;
            end
            else
            begin
                want = pending_results.pop_front();
                if (result.x_out !== want.x_out)
                begin
                    $display("%0t: x_out expected %0d actual %0d", $time, want.x_out,
                             result.x_out);
                    failed = 1'b1;
                end
                if (result.y_out !== want.y_out)
                begin
                    $display("%0t: y_out expected %0d actual %0d", $time, want.y_out,
                             result.y_out);
                    failed = 1'b1;
                end
            end
        end
        if (cycle_count > CYCLE_CAP)
        begin
            $display("analog_stick_radial_deadzone test failed");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        sample_valid = 1'b0;
        sample = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        cycle_count = 0;
        failed = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        cal_x_low = 12'd0;
        cal_x_center = SAMPLE_MID;
        cal_x_high = SAMPLE_MAX;
        cal_y_low = 12'd0;
        cal_y_center = SAMPLE_MID;
        cal_y_high = SAMPLE_MAX;
        cal_inner = DEAD_INNER_RST;
        cal_outer = DEAD_OUTER_RST;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_directed_defaults();
        test_special_calibrations();
        test_idle_phases();
        test_random_calibrations();
        drain_results();
        if (!failed && pending_results.size() == 0)
            $display("analog_stick_radial_deadzone test passed");
        else
            $display("analog_stick_radial_deadzone test failed");
        $finish;
    end
endmodule

### files.f
hw/rtl/asrd_pkg.sv
hw/rtl/asrd_fdiv.sv
hw/rtl/asrd_sqrt.sv
hw/rtl/analog_stick_radial_deadzone.sv
hw/rtl/asrd_checker.sv
verif/analog_stick_radial_deadzone_tb.sv
